// ===== src/bbm_pkg.sv =====
// ----------------------------------------------------------------------------
// bbm_pkg
// Shared types, codes and helpers for the backplane bus master sequencer.
// ----------------------------------------------------------------------------
package bbm_pkg;

    // full width of the slot bit vectors
    localparam int MaskW = 8;

    // sequencer states, codes as seen on state_code
    typedef enum logic [3:0] {
        ST_INIT        = 4'd0,
        ST_IDLE        = 4'd1,
        ST_ENUM        = 4'd2,
        ST_SEND_QUERY  = 4'd3,
        ST_WAIT_ANSWER = 4'd4,
        ST_TIMEOUT     = 4'd5,
        ST_SEND_ENQ    = 4'd6,
        ST_WAIT_ENQ    = 4'd7,
        ST_ACK         = 4'd8,
        ST_LISTEN      = 4'd9,
        ST_ERROR       = 4'd10
    } fsm_state_t;

    // message kinds sent to a card
    typedef enum logic [1:0] {
        KIND_NONE       = 2'd0,
        KIND_IRQ_INQ    = 2'd1,
        KIND_ACK        = 2'd2,
        KIND_ENUM_QUERY = 2'd3
    } send_kind_t;

    // one sampled tick of the bus interface
    typedef struct packed {
        logic        bus_requested;
        logic [7:0]  irq_pending;
        logic [7:0]  slots_occupied;
        logic        msg_valid;
        logic        msg_is_enum_answer;
        logic [2:0]  msg_dest_slot;
        logic [31:0] now_ticks;
    } bbm_tick_t;

    // one result of a tick
    typedef struct packed {
        logic [7:0]  select_mask;
        logic        select_update;
        send_kind_t  send_kind;
        logic [2:0]  send_slot;
        logic        msg_consume;
        fsm_state_t  state_code;
        logic [15:0] bus_errors;
        logic [7:0]  enumerated_mask;
    } bbm_result_t;

    // sequencer context carried from tick to tick
    typedef struct packed {
        fsm_state_t  fsm_state;
        logic [3:0]  enum_slot;
        logic [15:0] error_count;
        logic [2:0]  requester_slot;
        logic [2:0]  dest_slot;
        logic [31:0] wait_start;
        logic [7:0]  populated_mask;
        logic [7:0]  answered_mask;
        logic [7:0]  select_mask;
    } bbm_ctx_t;

    // one-hot select bit of a slot, limited to the slots on the backplane
    function automatic logic [MaskW-1:0] slot_bit(input logic [2:0] slot,
                                                   input logic [MaskW-1:0] mask);
        logic [MaskW-1:0] onehot;
        onehot = MaskW'(1) << slot;
        return onehot & mask;
    endfunction

endpackage

// ===== src/backplane_bus_master_fsm.sv =====
// ----------------------------------------------------------------------------
// backplane_bus_master_fsm
// Backplane bus master: slot enumeration and bus request arbitration.
// ----------------------------------------------------------------------------
// A tick is held in the input register, its result in the result register.
// Throughput: one tick per cycle while m_tready allows; the input register
// can still take one tick while a result waits, then input stalls until m_tready.
// Reset (aresetn low, synchronous): sequencer back to init with cleared
// counters and masks, timeout_ticks back to 100, both stages empty.
module backplane_bus_master_fsm #(
    parameter int NUM_SLOTS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration: timeout_ticks
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    // input ticks
    input  logic        s_tvalid,
    output logic        s_tready,
    // [0] bus_requested, [8:1] irq_pending, [16:9] slots_occupied,
    // [17] msg_valid, [18] msg_is_enum_answer, [21:19] msg_dest_slot,
    // [53:22] now_ticks, [55:54] zero
    input  logic [55:0] s_tdata,
    // results
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] select_mask, [8] select_update, [10:9] send_kind,
    // [13:11] send_slot, [14] msg_consume, [18:15] state_code,
    // [34:19] bus_errors, [42:35] enumerated_mask, [47:43] zero
    output logic [47:0] m_tdata
);

    logic                  in_valid_reg;
    bbm_pkg::bbm_tick_t    in_tick_reg;
    logic                  out_valid_reg;
    bbm_pkg::bbm_result_t  out_result_reg;
    bbm_pkg::bbm_ctx_t     ctx_reg;
    bbm_pkg::bbm_ctx_t     ctx_next;
    bbm_pkg::bbm_result_t  step_result;
    bbm_pkg::bbm_tick_t    s_tick;
    logic [31:0]           timeout_reg;
    logic                  advance;
    logic                  in_take;

    // unpack the input transfer
    assign s_tick.bus_requested      = s_tdata[0];
    assign s_tick.irq_pending        = s_tdata[8:1];
    assign s_tick.slots_occupied     = s_tdata[16:9];
    assign s_tick.msg_valid          = s_tdata[17];
    assign s_tick.msg_is_enum_answer = s_tdata[18];
    assign s_tick.msg_dest_slot      = s_tdata[21:19];
    assign s_tick.now_ticks          = s_tdata[53:22];

    // handshake: move the held tick on when the result register frees up
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign in_take  = s_tvalid && s_tready;

    // timeout register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= 32'd100;
        end else if (cfg_wr_en) begin
            timeout_reg <= cfg_wr_data;
        end
    end

    // input stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            in_tick_reg <= s_tick;
        end
    end

    // sequencer logic for the held tick
    bbm_step #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_step (
        .ctx           (ctx_reg),
        .tick          (in_tick_reg),
        .timeout_ticks (timeout_reg),
        .ctx_next      (ctx_next),
        .result        (step_result)
    );

    // sequencer context, init state is code zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctx_reg <= '0;
        end else if (advance) begin
            ctx_reg <= ctx_next;
        end
    end

    // result stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_result_reg <= step_result;
        end
    end

    // pack the result transfer
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0,
                       out_result_reg.enumerated_mask,
                       out_result_reg.bus_errors,
                       out_result_reg.state_code,
                       out_result_reg.msg_consume,
                       out_result_reg.send_slot,
                       out_result_reg.send_kind,
                       out_result_reg.select_update,
                       out_result_reg.select_mask};

endmodule

// ===== src/bbm_step.sv =====
// ----------------------------------------------------------------------------
// bbm_step
// Next-state and result logic of the sequencer for one tick.
// ----------------------------------------------------------------------------
module bbm_step #(
    parameter int NUM_SLOTS = 8
) (
    input  bbm_pkg::bbm_ctx_t    ctx,
    input  bbm_pkg::bbm_tick_t   tick,
    input  logic [31:0]          timeout_ticks,
    output bbm_pkg::bbm_ctx_t    ctx_next,
    output bbm_pkg::bbm_result_t result
);

    localparam logic [bbm_pkg::MaskW-1:0] SlotMask =
        bbm_pkg::MaskW'((1 << NUM_SLOTS) - 1);
    localparam logic [3:0] LastSlot = 4'(NUM_SLOTS);

    logic [31:0] deadline;
    logic        timed_out;
    logic        irq_found;
    logic [2:0]  irq_slot;
    logic [2:0]  cur_slot;

    // answer deadline, wraps at 32 bits
    assign deadline  = ctx.wait_start + timeout_ticks;
    assign timed_out = deadline < tick.now_ticks;
    assign cur_slot  = ctx.enum_slot[2:0];

    // lowest pending irq slot at or above 1
    always_comb begin
        irq_found = 1'b0;
        irq_slot  = 3'd0;
        for (int i = NUM_SLOTS - 1; i >= 1; i--) begin
            if (tick.irq_pending[i]) begin
                irq_found = 1'b1;
                irq_slot  = 3'(i);
            end
        end
    end

    // state transition and message generation
    always_comb begin
        ctx_next             = ctx;
        result.select_update = 1'b0;
        result.send_kind     = bbm_pkg::KIND_NONE;
        result.send_slot     = 3'd0;
        result.msg_consume   = 1'b0;

        case (ctx.fsm_state)
            bbm_pkg::ST_INIT: begin
                ctx_next.fsm_state = bbm_pkg::ST_ENUM;
            end
            bbm_pkg::ST_IDLE: begin
                if (tick.bus_requested) begin
                    ctx_next.fsm_state = bbm_pkg::ST_SEND_ENQ;
                end
            end
            bbm_pkg::ST_ENUM: begin
                ctx_next.populated_mask = tick.slots_occupied & SlotMask;
                ctx_next.enum_slot      = 4'd1;
                ctx_next.fsm_state      = bbm_pkg::ST_SEND_QUERY;
            end
            bbm_pkg::ST_SEND_QUERY: begin
                if (ctx.enum_slot >= LastSlot) begin
                    ctx_next.fsm_state = bbm_pkg::ST_IDLE;
                end else if ((ctx.populated_mask &
                              bbm_pkg::slot_bit(cur_slot, SlotMask)) == '0) begin
                    ctx_next.enum_slot = ctx.enum_slot + 4'd1;
                end else begin
                    ctx_next.select_mask = bbm_pkg::slot_bit(cur_slot, SlotMask);
                    result.select_update = 1'b1;
                    result.send_kind     = bbm_pkg::KIND_ENUM_QUERY;
                    result.send_slot     = cur_slot;
                    ctx_next.wait_start  = tick.now_ticks;
                    ctx_next.fsm_state   = bbm_pkg::ST_WAIT_ANSWER;
                end
            end
            bbm_pkg::ST_WAIT_ANSWER: begin
                if (timed_out) begin
                    ctx_next.fsm_state = bbm_pkg::ST_TIMEOUT;
                end else if (tick.msg_valid) begin
                    result.msg_consume = 1'b1;
                    if (!tick.msg_is_enum_answer) begin
                        // wrong reply type, keep waiting
                        ctx_next.error_count = ctx.error_count + 16'd1;
                    end else begin
                        ctx_next.answered_mask = ctx.answered_mask |
                            bbm_pkg::slot_bit(cur_slot, SlotMask);
                        ctx_next.enum_slot = ctx.enum_slot + 4'd1;
                        ctx_next.fsm_state = bbm_pkg::ST_SEND_QUERY;
                    end
                end
            end
            bbm_pkg::ST_TIMEOUT: begin
                ctx_next.error_count = ctx.error_count + 16'd1;
                ctx_next.enum_slot   = ctx.enum_slot + 4'd1;
                ctx_next.fsm_state   = bbm_pkg::ST_SEND_QUERY;
            end
            bbm_pkg::ST_SEND_ENQ: begin
                if (irq_found) begin
                    ctx_next.requester_slot = irq_slot;
                    ctx_next.select_mask    = bbm_pkg::slot_bit(irq_slot, SlotMask);
                    result.select_update    = 1'b1;
                    result.send_kind        = bbm_pkg::KIND_IRQ_INQ;
                    ctx_next.fsm_state      = bbm_pkg::ST_WAIT_ENQ;
                end else begin
                    ctx_next.fsm_state = bbm_pkg::ST_IDLE;
                end
            end
            bbm_pkg::ST_WAIT_ENQ: begin
                if (tick.msg_valid) begin
                    ctx_next.dest_slot = tick.msg_dest_slot;
                    result.msg_consume = 1'b1;
                    ctx_next.fsm_state = bbm_pkg::ST_ACK;
                end
            end
            bbm_pkg::ST_ACK: begin
                result.send_kind     = bbm_pkg::KIND_ACK;
                ctx_next.select_mask = bbm_pkg::slot_bit(ctx.dest_slot, SlotMask) |
                                       bbm_pkg::slot_bit(ctx.requester_slot, SlotMask);
                result.select_update = 1'b1;
                ctx_next.fsm_state   = bbm_pkg::ST_LISTEN;
            end
            bbm_pkg::ST_LISTEN: begin
                if (tick.msg_valid) begin
                    ctx_next.select_mask = '0;
                    result.select_update = 1'b1;
                    result.msg_consume   = 1'b1;
                    ctx_next.fsm_state   = bbm_pkg::ST_IDLE;
                end
            end
            default: begin
                ctx_next.fsm_state = bbm_pkg::ST_ERROR;
            end
        endcase

        result.select_mask     = ctx_next.select_mask;
        result.state_code      = ctx_next.fsm_state;
        result.bus_errors      = ctx_next.error_count;
        result.enumerated_mask = ctx_next.answered_mask;
    end

endmodule

// ===== tb/tb_backplane_bus_master_fsm.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_backplane_bus_master_fsm
// Self-checking bench for the backplane bus master sequencer. A tick-level
// predictor runs alongside the block and works out the status each input
// transfer should produce. Every result transfer is compared field by field
// with the oldest prediction. The bench first walks a directed enumeration
// covering answers, a wrong reply, an empty slot, timeouts and a wrapping
// deadline. It then runs directed bus grants, and after those randomized
// request / inquiry / acknowledge traffic with noise in the unused fields.
// The sender pauses in random bursts and the receiver stalls on a pattern.
// ----------------------------------------------------------------------------
module tb_backplane_bus_master_fsm;

    localparam int SLOTS       = 8;
    localparam int CYCLE_LIMIT = 200000;

    logic        aclk;
    logic        aresetn     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [31:0] cfg_wr_data = 32'd0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata     = 56'd0;
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [47:0] m_tdata;

    // predictor copy of the sequencer context
    bbm_pkg::fsm_state_t seq_state;
    logic [3:0]  seq_enum_slot;
    logic [15:0] seq_errors;
    logic [2:0]  seq_requester;
    logic [2:0]  seq_dest;
    logic [31:0] seq_wait_start;
    logic [7:0]  seq_populated;
    logic [7:0]  seq_answered;
    logic [7:0]  seq_select;
    logic [31:0] seq_timeout;

    bbm_pkg::bbm_result_t tick_status_q[$];
    int          mismatches  = 0;
    int          cycle_count = 0;
    int          burst_left  = 0;
    logic [31:0] ticks_now   = 32'd0;
    logic [15:0] rx_pattern  = 16'hFFFF;
    logic [7:0]  rx_phase    = 8'd0;

    backplane_bus_master_fsm #(
        .NUM_SLOTS(SLOTS)
    ) dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic logic [7:0] slot_select(input logic [2:0] slot);
        return 8'd1 << slot;
    endfunction

    // fields from the lowest bit up, zero fill on top
    function automatic logic [55:0] pack_tick(input bbm_pkg::bbm_tick_t t);
        return {2'b00, t.now_ticks, t.msg_dest_slot, t.msg_is_enum_answer,
                t.msg_valid, t.slots_occupied, t.irq_pending, t.bus_requested};
    endfunction

    // one scheduler tick of the sequencer, returns the status it reports
    function automatic bbm_pkg::bbm_result_t advance_sequencer(input bbm_pkg::bbm_tick_t t);
        bbm_pkg::bbm_result_t r;
        logic [31:0] deadline;
        r = '0;
        deadline = seq_wait_start + seq_timeout;
        case (seq_state)
            bbm_pkg::ST_INIT: seq_state = bbm_pkg::ST_ENUM;
            bbm_pkg::ST_IDLE: if (t.bus_requested) seq_state = bbm_pkg::ST_SEND_ENQ;
            bbm_pkg::ST_ENUM: begin
                seq_populated = t.slots_occupied;
                seq_enum_slot = 4'd1;
                seq_state = bbm_pkg::ST_SEND_QUERY;
            end
            bbm_pkg::ST_SEND_QUERY: begin
                if (seq_enum_slot >= 4'(SLOTS)) begin
                    seq_state = bbm_pkg::ST_IDLE;
                end else if (!seq_populated[seq_enum_slot[2:0]]) begin
                    seq_enum_slot = seq_enum_slot + 4'd1;
                end else begin
                    seq_select = slot_select(seq_enum_slot[2:0]);
                    r.select_update = 1'b1;
                    r.send_kind = bbm_pkg::KIND_ENUM_QUERY;
                    r.send_slot = seq_enum_slot[2:0];
                    seq_wait_start = t.now_ticks;
                    seq_state = bbm_pkg::ST_WAIT_ANSWER;
                end
            end
            bbm_pkg::ST_WAIT_ANSWER: begin
                // deadline check comes before the message
                if (deadline < t.now_ticks) begin
                    seq_state = bbm_pkg::ST_TIMEOUT;
                end else if (t.msg_valid) begin
                    r.msg_consume = 1'b1;
                    if (!t.msg_is_enum_answer) begin
                        seq_errors = seq_errors + 16'd1;
                    end else begin
                        seq_answered = seq_answered | slot_select(seq_enum_slot[2:0]);
                        seq_enum_slot = seq_enum_slot + 4'd1;
                        seq_state = bbm_pkg::ST_SEND_QUERY;
                    end
                end
            end
            bbm_pkg::ST_TIMEOUT: begin
                seq_errors = seq_errors + 16'd1;
                seq_enum_slot = seq_enum_slot + 4'd1;
                seq_state = bbm_pkg::ST_SEND_QUERY;
            end
            bbm_pkg::ST_SEND_ENQ: begin
                // lowest pending slot above zero wins
                seq_state = bbm_pkg::ST_IDLE;
                for (int s = 1; s < SLOTS; s++) begin
                    if (t.irq_pending[s] && seq_state == bbm_pkg::ST_IDLE) begin
                        seq_requester = 3'(s);
                        seq_select = slot_select(3'(s));
                        r.select_update = 1'b1;
                        r.send_kind = bbm_pkg::KIND_IRQ_INQ;
                        seq_state = bbm_pkg::ST_WAIT_ENQ;
                    end
                end
            end
            bbm_pkg::ST_WAIT_ENQ: begin
                if (t.msg_valid) begin
                    seq_dest = t.msg_dest_slot;
                    r.msg_consume = 1'b1;
                    seq_state = bbm_pkg::ST_ACK;
                end
            end
            bbm_pkg::ST_ACK: begin
                r.send_kind = bbm_pkg::KIND_ACK;
                seq_select = slot_select(seq_dest) | slot_select(seq_requester);
                r.select_update = 1'b1;
                seq_state = bbm_pkg::ST_LISTEN;
            end
            bbm_pkg::ST_LISTEN: begin
                if (t.msg_valid) begin
                    seq_select = 8'd0;
                    r.select_update = 1'b1;
                    r.msg_consume = 1'b1;
                    seq_state = bbm_pkg::ST_IDLE;
                end
            end
            default: seq_state = bbm_pkg::ST_ERROR;
        endcase
        r.select_mask = seq_select;
        r.state_code = seq_state;
        r.bus_errors = seq_errors;
        r.enumerated_mask = seq_answered;
        return r;
    endfunction

    function automatic void compare_field(input string name, input logic [31:0] want,
                                          input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // result side: check each transfer, stall on a rolling pattern
    always @(posedge aclk) begin
        bbm_pkg::bbm_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (tick_status_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
                mismatches++;
            end else begin
                want = tick_status_q.pop_front();
                compare_field("select_mask", 32'(want.select_mask), 32'(m_tdata[7:0]));
                compare_field("select_update", 32'(want.select_update), 32'(m_tdata[8]));
                compare_field("send_kind", 32'(want.send_kind), 32'(m_tdata[10:9]));
                compare_field("send_slot", 32'(want.send_slot), 32'(m_tdata[13:11]));
                compare_field("msg_consume", 32'(want.msg_consume), 32'(m_tdata[14]));
                compare_field("state_code", 32'(want.state_code), 32'(m_tdata[18:15]));
                compare_field("bus_errors", 32'(want.bus_errors), 32'(m_tdata[34:19]));
                compare_field("enumerated_mask", 32'(want.enumerated_mask),
                              32'(m_tdata[42:35]));
            end
        end
        rx_phase <= rx_phase + 8'd1;
        if (rx_phase[6:0] == 7'd0)
            rx_pattern <= ($urandom_range(0, 2) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
        m_tready <= rx_pattern[rx_phase[3:0]];
    end

    // one input transfer, with burst gaps; predicts at acceptance
    task automatic send_tick(input bbm_pkg::bbm_tick_t t);
        int idle_gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            idle_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
            if (idle_gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (idle_gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata <= pack_tick(t);
        do @(posedge aclk); while (!s_tready);
        tick_status_q.push_back(advance_sequencer(t));
    endtask

    task automatic apply_reset();
        aresetn <= 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        seq_state = bbm_pkg::ST_INIT;
        seq_enum_slot = 4'd0;
        seq_errors = 16'd0;
        seq_requester = 3'd0;
        seq_dest = 3'd0;
        seq_wait_start = 32'd0;
        seq_populated = 8'd0;
        seq_answered = 8'd0;
        seq_select = 8'd0;
        seq_timeout = 32'd100;
        @(posedge aclk);
    endtask

    // timeout register write, only once the block has drained
    task automatic load_timeout(input logic [31:0] ticks);
        s_tvalid <= 1'b0;
        while (tick_status_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= ticks;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        seq_timeout = ticks;
        burst_left = 0;
    endtask

    // enumeration after reset, timeout register at 3
    task automatic test_enumeration();
        bbm_pkg::bbm_tick_t t;
        bit wrong_sent;
        int polls;
        logic [31:0] deadline;
        wrong_sent = 1'b0;
        polls = 0;
        while (seq_state != bbm_pkg::ST_IDLE) begin
            t = '0;
            t.now_ticks = ticks_now;
            case (seq_state)
                // all fields high are ignored in init
                bbm_pkg::ST_INIT: t = '1;
                // slot 0 occupied but never queried, slot 3 empty
                bbm_pkg::ST_ENUM: t.slots_occupied = 8'b1111_0111;
                bbm_pkg::ST_SEND_QUERY: begin
                    polls = 0;
                    // deadline of slot 6 wraps past zero
                    if (seq_enum_slot == 4'd6) t.now_ticks = 32'hFFFF_FFFE;
                end
                bbm_pkg::ST_WAIT_ANSWER: begin
                    deadline = seq_wait_start + seq_timeout;
                    t.msg_valid = 1'b1;
                    t.msg_is_enum_answer = 1'b1;
                    t.now_ticks = seq_wait_start + 32'd1;
                    case (seq_enum_slot)
                        4'd2: begin
                            // wrong reply first, then the answer
                            if (!wrong_sent) begin
                                t.msg_is_enum_answer = 1'b0;
                                t.msg_dest_slot = 3'd7;
                                wrong_sent = 1'b1;
                            end
                        end
                        4'd4: begin
                            // exactly at the deadline, then one past it
                            t.msg_valid = 1'b0;
                            t.now_ticks = (polls == 0) ? deadline : deadline + 32'd1;
                        end
                        // timeout wins over a valid answer
                        4'd5: t.now_ticks = deadline + 32'd1;
                        4'd6: t.now_ticks = 32'hFFFF_FFFF;
                        default: ;
                    endcase
                    polls++;
                end
                default: ;
            endcase
            send_tick(t);
            ticks_now = t.now_ticks + 32'd1;
        end
    endtask

    function automatic bbm_pkg::bbm_tick_t bus_tick(input logic req, input logic [7:0] irq,
                                                    input logic mvalid,
                                                    input logic [2:0] dest);
        bbm_pkg::bbm_tick_t t;
        t.bus_requested = req;
        t.irq_pending = irq;
        t.slots_occupied = 8'($urandom);
        t.msg_valid = mvalid;
        t.msg_is_enum_answer = 1'($urandom);
        t.msg_dest_slot = dest;
        t.now_ticks = $urandom;
        return t;
    endfunction

    // directed grants: no request, only slot 0 pending, lowest and highest requester
    task automatic test_bus_grant();
        send_tick(bus_tick(1'b0, 8'hFF, 1'b1, 3'd0));
        // only slot 0 pending: back to idle
        send_tick(bus_tick(1'b1, 8'h00, 1'b0, 3'd0));
        send_tick(bus_tick(1'b0, 8'h01, 1'b1, 3'd0));
        // slot 1 wins, waits for its reply, talks to slot 7
        send_tick(bus_tick(1'b1, 8'h00, 1'b0, 3'd0));
        send_tick(bus_tick(1'b0, 8'hFF, 1'b0, 3'd0));
        send_tick(bus_tick(1'b0, 8'h00, 1'b0, 3'd0));
        send_tick(bus_tick(1'b0, 8'h00, 1'b1, 3'd7));
        send_tick(bus_tick(1'b0, 8'h00, 1'b0, 3'd0));
        send_tick(bus_tick(1'b0, 8'h00, 1'b0, 3'd0));
        send_tick(bus_tick(1'b0, 8'h00, 1'b1, 3'd0));
        // slot 7 talks to itself
        send_tick(bus_tick(1'b1, 8'h00, 1'b0, 3'd0));
        send_tick(bus_tick(1'b0, 8'h80, 1'b0, 3'd0));
        send_tick(bus_tick(1'b0, 8'h00, 1'b1, 3'd7));
        send_tick(bus_tick(1'b1, 8'hFF, 1'b1, 3'd2));
        send_tick(bus_tick(1'b0, 8'h00, 1'b1, 3'd5));
    endtask

    // random grant traffic; ticks that leave the state alone do not count
    task automatic test_random_traffic(input int n_active);
        bbm_pkg::bbm_tick_t t;
        bbm_pkg::fsm_state_t prior;
        int active;
        active = 0;
        while (active < n_active) begin
            prior = seq_state;
            t.bus_requested = (seq_state == bbm_pkg::ST_IDLE) ? ($urandom_range(0, 99) < 60)
                                                              : 1'($urandom);
            case ($urandom_range(0, 9))
                0: t.irq_pending = 8'h00;
                1: t.irq_pending = 8'h01;
                2, 3: t.irq_pending = (8'd1 << $urandom_range(1, 7)) | 8'($urandom_range(0, 1));
                default: t.irq_pending = 8'($urandom);
            endcase
            t.slots_occupied = 8'($urandom);
            case (seq_state)
                bbm_pkg::ST_WAIT_ENQ: t.msg_valid = ($urandom_range(0, 99) < 65);
                bbm_pkg::ST_LISTEN: t.msg_valid = ($urandom_range(0, 99) < 55);
                default: t.msg_valid = 1'($urandom);
            endcase
            t.msg_is_enum_answer = 1'($urandom);
            t.msg_dest_slot = 3'($urandom);
            t.now_ticks = $urandom;
            send_tick(t);
            if (seq_state != prior) active++;
        end
    endtask

    initial begin
        apply_reset();
        load_timeout(32'hFFFF_FFFF);
        load_timeout(32'd3);
        test_enumeration();
        load_timeout(32'd0);
        test_bus_grant();
        load_timeout($urandom);
        test_random_traffic(180);
        load_timeout(32'hFFFF_FFFF);
        test_random_traffic(180);

        // drain, then let the pipeline settle
        s_tvalid <= 1'b0;
        while (tick_status_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== backplane_bus_master_fsm.f =====
src/bbm_pkg.sv
src/bbm_step.sv
src/backplane_bus_master_fsm.sv
tb/tb_backplane_bus_master_fsm.sv
